// File: rtl/video_frame_drop_monitor_defines.svh
// Assertion macros used by the frame drop monitor statistics module (vfdm_stats).
`ifndef VIDEO_FRAME_DROP_MONITOR_DEFINES_SVH
`define VIDEO_FRAME_DROP_MONITOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define VFDM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vfdm same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define VFDM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vfdm next-cycle check failed");

`endif

// File: rtl/vfdm_pkg.sv
// Types and constants shared by the frame drop monitor modules.
`timescale 1ns / 1ps

package vfdm_pkg;

    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned S_TDATA_W  = 96;
    localparam int unsigned M_TDATA_W  = 264;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_WARMUP    = 2'd0;
    localparam logic [1:0] REG_TOLERANCE = 2'd1;
    localparam logic [1:0] REG_THRESHOLD = 2'd2;

    localparam logic [7:0]  WARMUP_RESET    = 8'd5;
    localparam logic [15:0] TOLERANCE_RESET = 16'd16;
    localparam logic [23:0] THRESHOLD_RESET = 24'd1024;

    // Pixel format codes
    localparam logic [2:0] FMT_GRAY8  = 3'd0;
    localparam logic [2:0] FMT_GRAY16 = 3'd1;
    localparam logic [2:0] FMT_YUYV   = 3'd2;

    // Frame class codes
    localparam logic [1:0] CLASS_UNCHECKED = 2'd0;
    localparam logic [1:0] CLASS_COMPLETE  = 2'd1;
    localparam logic [1:0] CLASS_MINOR     = 2'd2;
    localparam logic [1:0] CLASS_REAL      = 2'd3;

    typedef struct packed {
        logic [7:0]  warmup_frames;
        logic [15:0] header_tolerance;
        logic [23:0] real_drop_threshold;
    } t_cfg;

    typedef struct packed {
        logic [31:0] sequence_req;
        logic [15:0] frame_width;
        logic [15:0] frame_height;
        logic [2:0]  pixel_format;
        logic [31:0] byte_count;
    } t_item;

    typedef struct packed {
        logic [1:0]  frame_class;
        logic [31:0] sequence_gap;
        logic [32:0] shortfall;
        logic [31:0] total_frame_count;
        logic [31:0] dropped_count;
        logic [31:0] real_drop_count;
        logic [31:0] minor_short_count;
        logic [63:0] total_byte_count;
    } t_result;

endpackage

// File: rtl/video_frame_drop_monitor.sv
// Top level of the frame drop monitor: input register, stats update, result register.
`timescale 1ns / 1ps

// Usage:
//   Slave stream s_axis_* carries one delivered-frame descriptor per word;
//   master stream m_axis_* returns one result word per descriptor once the
//   warmup count is used up (warmup descriptors give no result).
//   APB port sets warmup_frames (0x0), header_tolerance (0x4) and
//   real_drop_threshold (0x8); write it only while no descriptor is in flight.
// Path: a descriptor is taken into the input register, checked in the
//   stats update and registered in the result register behind m_axis_tvalid.
// Throughput: one descriptor per cycle while m_axis_tready does not stall; the
//   16x16 size multiply, shortfall compare and counter adds fit the update stage.
// Reset: counters, last sequence and warmup count clear, registers take
//   their defaults (5, 16, 1024); no clearing sweep is needed.
// Stall: when m_axis_tready is low the result word holds; the input
//   register still takes one descriptor, then s_axis_tready drops.

module video_frame_drop_monitor (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // APB configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [vfdm_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [vfdm_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [vfdm_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    // descriptor stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // sequence_req[31:0], frame_width[47:32], frame_height[63:48], byte_count[95:64]
    input  logic [vfdm_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // pixel_format[2:0]
    input  logic [2:0]                         s_axis_tuser,
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // sequence_gap[31:0], shortfall[64:32], total_frame_count[96:65],
    // dropped_count[128:97], real_drop_count[160:129],
    // minor_short_count[192:161], total_byte_count[256:193], zero[263:257]
    output logic [vfdm_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // frame_class[1:0]
    output logic [1:0]                         m_axis_tuser
);

    vfdm_pkg::t_cfg    cfg;
    vfdm_pkg::t_item   r_in;
    vfdm_pkg::t_result r_out;
    vfdm_pkg::t_result result;
    logic              r_in_valid;
    logic              r_out_valid;
    logic              out_free;
    logic              advance;
    logic              in_fire;
    logic              emit;

    vfdm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    vfdm_stats u_stats (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_fire   (advance),
        .i_item   (r_in),
        .o_emit   (emit),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= emit;
            end
        end
    end

    // hold payload while its stage is stalled
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in.sequence_req <= s_axis_tdata[31:0];
            r_in.frame_width  <= s_axis_tdata[47:32];
            r_in.frame_height <= s_axis_tdata[63:48];
            r_in.byte_count   <= s_axis_tdata[95:64];
            r_in.pixel_format <= s_axis_tuser;
        end
        if (emit) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.frame_class;
    assign m_axis_tdata  = {7'd0,
                            r_out.total_byte_count,
                            r_out.minor_short_count,
                            r_out.real_drop_count,
                            r_out.dropped_count,
                            r_out.total_frame_count,
                            r_out.shortfall,
                            r_out.sequence_gap};

endmodule

// File: rtl/vfdm_cfg.sv
// APB register file holding the warmup count and the two shortfall thresholds.
`timescale 1ns / 1ps

module vfdm_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [vfdm_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [vfdm_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [vfdm_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,
    output vfdm_pkg::t_cfg                     o_cfg
);

    vfdm_pkg::t_cfg r_cfg;
    logic [1:0]     idx;
    logic           wr_en;

    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.warmup_frames       <= vfdm_pkg::WARMUP_RESET;
            r_cfg.header_tolerance    <= vfdm_pkg::TOLERANCE_RESET;
            r_cfg.real_drop_threshold <= vfdm_pkg::THRESHOLD_RESET;
        end else if (wr_en) begin
            case (idx)
                vfdm_pkg::REG_WARMUP:    r_cfg.warmup_frames       <= pwdata[7:0];
                vfdm_pkg::REG_TOLERANCE: r_cfg.header_tolerance    <= pwdata[15:0];
                vfdm_pkg::REG_THRESHOLD: r_cfg.real_drop_threshold <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            vfdm_pkg::REG_WARMUP:    prdata = {24'd0, r_cfg.warmup_frames};
            vfdm_pkg::REG_TOLERANCE: prdata = {16'd0, r_cfg.header_tolerance};
            vfdm_pkg::REG_THRESHOLD: prdata = {8'd0, r_cfg.real_drop_threshold};
            default:                 prdata = '0;
        endcase
    end

endmodule

// File: rtl/vfdm_stats.sv
// Statistics state and the per-frame sequence and size check.
`timescale 1ns / 1ps
`include "video_frame_drop_monitor_defines.svh"

module vfdm_stats (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vfdm_pkg::t_cfg    i_cfg,
    input  logic              i_fire,
    input  vfdm_pkg::t_item   i_item,
    output logic              o_emit,
    output vfdm_pkg::t_result o_result
);

    logic [7:0]  r_warmup_seen;
    logic [31:0] r_last_seq;
    logic [31:0] r_frames_total;
    logic [63:0] r_bytes_total;
    logic [31:0] r_drops_all;
    logic [31:0] r_drops_real;
    logic [31:0] r_shorts_minor;

    logic [31:0] n_frames_total;
    logic [63:0] n_bytes_total;
    logic [31:0] n_drops_all;
    logic [31:0] n_drops_real;
    logic [31:0] n_shorts_minor;

    logic        warm;
    logic [31:0] seq_next;
    logic [31:0] gap;
    logic [31:0] area;
    logic [32:0] expected;
    logic [32:0] bytes_ext;
    logic [32:0] sf;
    logic [1:0]  cls;
    logic        is_real;
    logic        is_minor;

    assign warm   = r_warmup_seen < i_cfg.warmup_frames;
    assign o_emit = i_fire && !warm;

    // Gap: frames skipped on a jump ahead, one on other breaks.
    assign seq_next = r_last_seq + 32'd1;
    always_comb begin
        gap = '0;
        if (r_last_seq != 32'd0 && i_item.sequence_req != seq_next) begin
            gap = (i_item.sequence_req > seq_next) ? (i_item.sequence_req - seq_next)
                                                   : 32'd1;
        end
    end

    assign area      = i_item.frame_width * i_item.frame_height;
    assign bytes_ext = {1'b0, i_item.byte_count};

    always_comb begin
        case (i_item.pixel_format)
            vfdm_pkg::FMT_GRAY8:  expected = {1'b0, area};
            vfdm_pkg::FMT_GRAY16: expected = {area, 1'b0};
            vfdm_pkg::FMT_YUYV:   expected = {area, 1'b0};
            default:              expected = '0;
        endcase
    end

    always_comb begin
        sf  = '0;
        cls = vfdm_pkg::CLASS_UNCHECKED;
        if (expected != 33'd0) begin
            if (expected > bytes_ext) begin
                sf = expected - bytes_ext;
                // tolerance test wins over the real-drop threshold
                if (sf <= {17'd0, i_cfg.header_tolerance}) begin
                    cls = vfdm_pkg::CLASS_MINOR;
                end else if (sf > {9'd0, i_cfg.real_drop_threshold}) begin
                    cls = vfdm_pkg::CLASS_REAL;
                end else begin
                    cls = vfdm_pkg::CLASS_MINOR;
                end
            end else begin
                cls = vfdm_pkg::CLASS_COMPLETE;
            end
        end
    end

    assign is_real  = (cls == vfdm_pkg::CLASS_REAL);
    assign is_minor = (cls == vfdm_pkg::CLASS_MINOR);

    assign n_frames_total = r_frames_total + 32'd1;
    assign n_bytes_total  = r_bytes_total + {32'd0, i_item.byte_count};
    assign n_drops_all    = r_drops_all + gap + {31'd0, is_real};
    assign n_drops_real   = r_drops_real + gap + {31'd0, is_real};
    assign n_shorts_minor = r_shorts_minor + {31'd0, is_minor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warmup_seen  <= '0;
            r_last_seq     <= '0;
            r_frames_total <= '0;
            r_bytes_total  <= '0;
            r_drops_all    <= '0;
            r_drops_real   <= '0;
            r_shorts_minor <= '0;
        end else if (i_fire) begin
            if (warm) begin
                r_warmup_seen <= r_warmup_seen + 8'd1;
            end else begin
                r_last_seq     <= i_item.sequence_req;
                r_frames_total <= n_frames_total;
                r_bytes_total  <= n_bytes_total;
                r_drops_all    <= n_drops_all;
                r_drops_real   <= n_drops_real;
                r_shorts_minor <= n_shorts_minor;
            end
        end
    end

    assign o_result.frame_class       = cls;
    assign o_result.sequence_gap      = gap;
    assign o_result.shortfall         = sf;
    assign o_result.total_frame_count = n_frames_total;
    assign o_result.dropped_count     = n_drops_all;
    assign o_result.real_drop_count   = n_drops_real;
    assign o_result.minor_short_count = n_shorts_minor;
    assign o_result.total_byte_count  = n_bytes_total;

    `VFDM_ASSERT_NEXT(a_frames_step, i_clk, i_rst_n, o_emit, r_frames_total == $past(r_frames_total) + 32'd1)
    `VFDM_ASSERT_NEXT(a_warmup_step, i_clk, i_rst_n, i_fire && warm, r_warmup_seen == $past(r_warmup_seen) + 8'd1)
    `VFDM_ASSERT_NOW(a_unchecked_zero, i_clk, i_rst_n, cls == vfdm_pkg::CLASS_UNCHECKED || cls == vfdm_pkg::CLASS_COMPLETE, sf == 33'd0)
    `VFDM_ASSERT_NOW(a_short_nonzero, i_clk, i_rst_n, is_real || is_minor, sf != 33'd0)

endmodule
